// ----- hw/rtl/rbpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbpc_pkg - ring buffer pointer control shared definitions
// Function codes, internal operation codes and sizing defaults.
// ----------------------------------------------------------------------------
package rbpc_pkg;

  localparam int RING_MAX_DEFAULT = 1024;
  localparam int SIZE_RESET       = 1024;
  localparam int SIZE_MIN         = 2;
  localparam int FUNC_W           = 3;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [FUNC_W-1:0] FUNC_WR_RESERVE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_COMMIT  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RD_RESERVE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CONSUME    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CONS_UPTO  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_PEEK       = 3'd5;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [2:0] {
    OP_WR_RESERVE,
    OP_WR_COMMIT,
    OP_RD_RESERVE,
    OP_CONSUME,
    OP_CONS_UPTO,
    OP_PEEK,
    OP_NONE
  } op_t;

  localparam int OP_W = $bits(op_t);

endpackage
`default_nettype wire

// ----- hw/rtl/ring_buffer_pointer_control.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_buffer_pointer_control - SPSC ring index controller
// Reserve/commit/consume/peek bookkeeping for a ring with one separator slot.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one operation per beat:
//   in_func selects the operation, in_count its slot count. Each beat gives
//   exactly one result beat on out_valid/out_stall with run lengths, totals,
//   fill level, free slots and the full flag.
//   cfg_wr_en/cfg_wr_data write the ring size (clamped to 2..RING_MAX) and
//   clear all pointers; write only while no operation is in flight.
//   From input accept, an operation passes the front end register, the queue
//   and the back end sequencer (dequeue, copy refresh, split/update, status)
//   before out_valid; the back end finishes one operation before the next.
//   A two-entry queue sits between front end and back end; the result is
//   held in an output register, so a stalled receiver only blocks the back
//   end once its result is done, and the front end keeps accepting until
//   the queue fills.
//   Reset (synchronous, rst_n low) sets ring size to min(1024, RING_MAX),
//   clears all pointers and drops any pending beats.
// ----------------------------------------------------------------------------
module ring_buffer_pointer_control #(
  parameter int  RING_MAX = rbpc_pkg::RING_MAX_DEFAULT,
  localparam int PTR_W    = $clog2(RING_MAX),
  localparam int SIZE_W   = $clog2(RING_MAX + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [SIZE_W-1:0]           cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [rbpc_pkg::FUNC_W-1:0] in_func,
  input  wire logic [SIZE_W-1:0]           in_count,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_status,
  output logic [PTR_W-1:0]                 out_offset,
  output logic [SIZE_W-1:0]                out_first_len,
  output logic [SIZE_W-1:0]                out_second_len,
  output logic [SIZE_W-1:0]                out_total,
  output logic [PTR_W-1:0]                 out_fill_level,
  output logic [PTR_W-1:0]                 out_free_slots,
  output logic                             out_is_full
);

  localparam int Q_W = rbpc_pkg::OP_W + SIZE_W;

  logic              q_full, q_push, q_pop, q_valid;
  rbpc_pkg::op_t     fr_op, bk_op;
  logic [SIZE_W-1:0] fr_count;
  logic [Q_W-1:0]    q_wr_data, q_rd_data;

  assign q_wr_data = {fr_op, fr_count};
  assign bk_op     = rbpc_pkg::op_t'(q_rd_data[SIZE_W +: rbpc_pkg::OP_W]);

  rbpc_front #(
    .SIZE_W (SIZE_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_func),
    .in_count (in_count),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (fr_op),
    .q_count  (fr_count)
  );

  rbpc_queue #(
    .DATA_W (Q_W),
    .DEPTH  (rbpc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_data (q_rd_data)
  );

  rbpc_back #(
    .RING_MAX (RING_MAX),
    .PTR_W    (PTR_W),
    .SIZE_W   (SIZE_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .q_valid        (q_valid),
    .q_op           (bk_op),
    .q_count        (q_rd_data[SIZE_W-1:0]),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_offset     (out_offset),
    .out_first_len  (out_first_len),
    .out_second_len (out_second_len),
    .out_total      (out_total),
    .out_fill_level (out_fill_level),
    .out_free_slots (out_free_slots),
    .out_is_full    (out_is_full)
  );

`ifndef SYNTH
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == rbpc_pkg::STATUS_ERR)) |->
      ((out_total == '0) && (out_first_len == '0) && (out_second_len == '0) &&
       (out_offset == '0)))
    else $error("error beat carries nonzero payload");

  a_full_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_full == (out_free_slots == '0)))
    else $error("full flag disagrees with free slot count");

  a_runs_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (((SIZE_W+1)'(out_first_len) + (SIZE_W+1)'(out_second_len)) <=
       (SIZE_W+1)'(out_total)))
    else $error("run lengths exceed reported total");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/rbpc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbpc_front - request front end
// Takes input beats, decodes the function code and hands them to the queue.
// ----------------------------------------------------------------------------
module rbpc_front #(
  parameter int SIZE_W = 11
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [rbpc_pkg::FUNC_W-1:0] in_func,
  input  wire logic [SIZE_W-1:0]           in_count,
  input  wire logic                        q_full,
  output logic                             q_push,
  output rbpc_pkg::op_t                    q_op,
  output logic [SIZE_W-1:0]                q_count
);

  logic                fr_valid_r, fr_valid_nxt;
  rbpc_pkg::op_t       fr_op_r, fr_op_nxt;
  logic [SIZE_W-1:0]   fr_count_r, fr_count_nxt;
  logic                accept;
  rbpc_pkg::op_t       dec_op;

  always_comb begin
    case (in_func)
      rbpc_pkg::FUNC_WR_RESERVE: dec_op = rbpc_pkg::OP_WR_RESERVE;
      rbpc_pkg::FUNC_WR_COMMIT:  dec_op = rbpc_pkg::OP_WR_COMMIT;
      rbpc_pkg::FUNC_RD_RESERVE: dec_op = rbpc_pkg::OP_RD_RESERVE;
      rbpc_pkg::FUNC_CONSUME:    dec_op = rbpc_pkg::OP_CONSUME;
      rbpc_pkg::FUNC_CONS_UPTO:  dec_op = rbpc_pkg::OP_CONS_UPTO;
      rbpc_pkg::FUNC_PEEK:       dec_op = rbpc_pkg::OP_PEEK;
      default:                   dec_op = rbpc_pkg::OP_NONE;
    endcase
  end

  assign q_push   = fr_valid_r && !q_full;
  assign in_stall = fr_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_op     = fr_op_r;
  assign q_count  = fr_count_r;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_op_nxt    = fr_op_r;
    fr_count_nxt = fr_count_r;
    if (q_push) begin
      fr_valid_nxt = 1'b0;
    end
    if (accept) begin
      fr_valid_nxt = 1'b1;
      fr_op_nxt    = dec_op;
      fr_count_nxt = in_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_op_r    <= fr_op_nxt;
    fr_count_r <= fr_count_nxt;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rbpc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbpc_queue - decoupling queue
// Small flop-based FIFO between the front end and the execution back end.
// ----------------------------------------------------------------------------
module rbpc_queue #(
  parameter int DATA_W = 14,
  parameter int DEPTH  = rbpc_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   valid,
  output logic [DATA_W-1:0]      rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     level_r, level_nxt;
  logic              do_push, do_pop;

  assign full    = (level_r == CW'(DEPTH));
  assign valid   = (level_r != '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + CW'(1);
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rbpc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbpc_back - pointer execution back end
// Holds ring size and pointers, executes one operation in three steps and
// drives the result register.
// ----------------------------------------------------------------------------
module rbpc_back #(
  parameter int RING_MAX = rbpc_pkg::RING_MAX_DEFAULT,
  parameter int PTR_W    = $clog2(RING_MAX),
  parameter int SIZE_W   = $clog2(RING_MAX + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [SIZE_W-1:0] cfg_wr_data,
  input  wire logic              q_valid,
  input  wire rbpc_pkg::op_t     q_op,
  input  wire logic [SIZE_W-1:0] q_count,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_status,
  output logic [PTR_W-1:0]       out_offset,
  output logic [SIZE_W-1:0]      out_first_len,
  output logic [SIZE_W-1:0]      out_second_len,
  output logic [SIZE_W-1:0]      out_total,
  output logic [PTR_W-1:0]       out_fill_level,
  output logic [PTR_W-1:0]       out_free_slots,
  output logic                   out_is_full
);

  localparam int RESET_SIZE = (RING_MAX < rbpc_pkg::SIZE_RESET) ? RING_MAX
                                                                : rbpc_pkg::SIZE_RESET;

  typedef enum logic [1:0] {S_IDLE, S_SEEN, S_APPLY, S_STAT} state_t;

  function automatic logic [PTR_W-1:0] items_f(input logic [PTR_W-1:0] h,
                                               input logic [PTR_W-1:0] t,
                                               input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] d;
    if (h >= t) begin
      d = SIZE_W'(h) - SIZE_W'(t);
    end else begin
      d = SIZE_W'(h) + n - SIZE_W'(t);
    end
    return PTR_W'(d);
  endfunction

  function automatic logic [PTR_W-1:0] adv_f(input logic [PTR_W-1:0] p,
                                             input logic [SIZE_W-1:0] a,
                                             input logic [SIZE_W-1:0] n);
    logic [SIZE_W:0] s;
    s = (SIZE_W+1)'(p) + (SIZE_W+1)'(a);
    if (s >= (SIZE_W+1)'(n)) begin
      s = s - (SIZE_W+1)'(n);
    end
    return PTR_W'(s);
  endfunction

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   ring_size_r, ring_size_nxt;
  logic [PTR_W-1:0]    wi_r, wi_nxt, ri_r, ri_nxt;
  logic [PTR_W-1:0]    wtc_r, wtc_nxt, rhc_r, rhc_nxt;
  rbpc_pkg::op_t       op_r, op_nxt;
  logic [SIZE_W-1:0]   count_r, count_nxt;
  logic [SIZE_W-1:0]   seen_r, seen_nxt;
  logic [PTR_W-1:0]    fill_r, fill_nxt;
  logic                res_status_r, res_status_nxt;
  logic [PTR_W-1:0]    res_offset_r, res_offset_nxt;
  logic [SIZE_W-1:0]   res_first_r, res_first_nxt;
  logic [SIZE_W-1:0]   res_second_r, res_second_nxt;
  logic [SIZE_W-1:0]   res_total_r, res_total_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_status_r, out_status_nxt;
  logic [PTR_W-1:0]    out_offset_r, out_offset_nxt;
  logic [SIZE_W-1:0]   out_first_r, out_first_nxt;
  logic [SIZE_W-1:0]   out_second_r, out_second_nxt;
  logic [SIZE_W-1:0]   out_total_r, out_total_nxt;
  logic [PTR_W-1:0]    out_fill_r, out_fill_nxt;
  logic [PTR_W-1:0]    out_free_r, out_free_nxt;
  logic                out_full_r, out_full_nxt;

  logic [PTR_W-1:0]    w_copy_items, r_old, r_new, st_fill;
  logic                r_refresh;
  logic [SIZE_W-1:0]   wa, wb, ra, rb, rn, room, rest, free_e, upto_amt, st_free;
  logic [SIZE_W-1:0]   wi_e, ri_e, wtc_e, rhc_e, fill_e;
  logic                out_load;

  assign q_pop          = (state_r == S_IDLE) && q_valid;
  assign out_load       = (state_r == S_STAT) && (!out_valid_r || !out_stall);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_offset     = out_offset_r;
  assign out_first_len  = out_first_r;
  assign out_second_len = out_second_r;
  assign out_total      = out_total_r;
  assign out_fill_level = out_fill_r;
  assign out_free_slots = out_free_r;
  assign out_is_full    = out_full_r;

  assign wi_e   = SIZE_W'(wi_r);
  assign ri_e   = SIZE_W'(ri_r);
  assign wtc_e  = SIZE_W'(wtc_r);
  assign rhc_e  = SIZE_W'(rhc_r);
  assign fill_e = SIZE_W'(fill_r);

  // step 1: copy refresh decisions
  always_comb begin
    w_copy_items = items_f(wi_r, wtc_r, ring_size_r);
    r_old        = items_f(rhc_r, ri_r, ring_size_r);
    r_new        = items_f(wi_r, ri_r, ring_size_r);
    case (op_r)
      rbpc_pkg::OP_RD_RESERVE: r_refresh = (r_old == '0);
      rbpc_pkg::OP_CONS_UPTO:  r_refresh = (SIZE_W'(r_old) < count_r);
      rbpc_pkg::OP_PEEK:       r_refresh = (SIZE_W'(r_old) < count_r);
      default:                 r_refresh = 1'b0;
    endcase
  end

  // step 2: splits and pointer moves
  always_comb begin
    if (wtc_e <= wi_e) begin
      if (wtc_r == '0) begin
        wa = ring_size_r - wi_e - SIZE_W'(1);
        wb = '0;
      end else begin
        wa = ring_size_r - wi_e;
        wb = wtc_e - SIZE_W'(1);
      end
    end else begin
      wa = wtc_e - wi_e - SIZE_W'(1);
      wb = '0;
    end
    rn = ((op_r == rbpc_pkg::OP_PEEK) && (count_r < seen_r)) ? count_r : seen_r;
    room = ring_size_r - ri_e;
    if (ri_e < rhc_e) begin
      ra   = rn;
      rest = '0;
      rb   = '0;
    end else begin
      ra   = (room > rn) ? rn : room;
      rest = rn - ra;
      rb   = (rhc_e < rest) ? rhc_e : rest;
    end
    free_e   = ring_size_r - SIZE_W'(1) - fill_e;
    upto_amt = (seen_r < count_r) ? seen_r : count_r;
  end

  // step 3: status from the true pointers
  always_comb begin
    st_fill = items_f(wi_r, ri_r, ring_size_r);
    st_free = ring_size_r - SIZE_W'(1) - SIZE_W'(st_fill);
  end

  always_comb begin
    state_nxt      = state_r;
    ring_size_nxt  = ring_size_r;
    wi_nxt         = wi_r;
    ri_nxt         = ri_r;
    wtc_nxt        = wtc_r;
    rhc_nxt        = rhc_r;
    op_nxt         = op_r;
    count_nxt      = count_r;
    seen_nxt       = seen_r;
    fill_nxt       = fill_r;
    res_status_nxt = res_status_r;
    res_offset_nxt = res_offset_r;
    res_first_nxt  = res_first_r;
    res_second_nxt = res_second_r;
    res_total_nxt  = res_total_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_total_nxt  = out_total_r;
    out_fill_nxt   = out_fill_r;
    out_free_nxt   = out_free_r;
    out_full_nxt   = out_full_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          op_nxt    = q_op;
          count_nxt = q_count;
          state_nxt = S_SEEN;
        end
      end
      S_SEEN: begin
        if ((op_r == rbpc_pkg::OP_WR_RESERVE) &&
            (SIZE_W'(w_copy_items) == ring_size_r - SIZE_W'(1))) begin
          wtc_nxt = ri_r;
        end
        if (r_refresh) begin
          rhc_nxt  = wi_r;
          seen_nxt = SIZE_W'(r_new);
        end else begin
          seen_nxt = SIZE_W'(r_old);
        end
        fill_nxt  = r_new;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        res_status_nxt = rbpc_pkg::STATUS_OK;
        res_offset_nxt = '0;
        res_first_nxt  = '0;
        res_second_nxt = '0;
        res_total_nxt  = '0;
        case (op_r)
          rbpc_pkg::OP_WR_RESERVE: begin
            res_offset_nxt = wi_r;
            res_first_nxt  = wa;
            res_second_nxt = wb;
            res_total_nxt  = wa + wb;
          end
          rbpc_pkg::OP_WR_COMMIT: begin
            if (count_r > free_e) begin
              res_status_nxt = rbpc_pkg::STATUS_ERR;
            end else begin
              wi_nxt        = adv_f(wi_r, count_r, ring_size_r);
              res_total_nxt = count_r;
            end
          end
          rbpc_pkg::OP_RD_RESERVE, rbpc_pkg::OP_PEEK: begin
            res_offset_nxt = ri_r;
            res_first_nxt  = ra;
            res_second_nxt = rb;
            res_total_nxt  = seen_r;
          end
          rbpc_pkg::OP_CONSUME: begin
            if ((count_r == '0) || (count_r > fill_e)) begin
              res_status_nxt = rbpc_pkg::STATUS_ERR;
            end else begin
              ri_nxt        = adv_f(ri_r, count_r, ring_size_r);
              res_total_nxt = count_r;
            end
          end
          rbpc_pkg::OP_CONS_UPTO: begin
            ri_nxt        = adv_f(ri_r, upto_amt, ring_size_r);
            res_total_nxt = upto_amt;
          end
          default: begin
          end
        endcase
        state_nxt = S_STAT;
      end
      S_STAT: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_offset_nxt = res_offset_r;
          out_first_nxt  = res_first_r;
          out_second_nxt = res_second_r;
          out_total_nxt  = res_total_r;
          out_fill_nxt   = st_fill;
          out_free_nxt   = PTR_W'(st_free);
          out_full_nxt   = (adv_f(wi_r, SIZE_W'(1), ring_size_r) == ri_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      if (cfg_wr_data < SIZE_W'(rbpc_pkg::SIZE_MIN)) begin
        ring_size_nxt = SIZE_W'(rbpc_pkg::SIZE_MIN);
      end else if (cfg_wr_data > SIZE_W'(RING_MAX)) begin
        ring_size_nxt = SIZE_W'(RING_MAX);
      end else begin
        ring_size_nxt = cfg_wr_data;
      end
      wi_nxt  = '0;
      ri_nxt  = '0;
      wtc_nxt = '0;
      rhc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ring_size_r <= SIZE_W'(RESET_SIZE);
      wi_r        <= '0;
      ri_r        <= '0;
      wtc_r       <= '0;
      rhc_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ring_size_r <= ring_size_nxt;
      wi_r        <= wi_nxt;
      ri_r        <= ri_nxt;
      wtc_r       <= wtc_nxt;
      rhc_r       <= rhc_nxt;
    end
    op_r         <= op_nxt;
    count_r      <= count_nxt;
    seen_r       <= seen_nxt;
    fill_r       <= fill_nxt;
    res_status_r <= res_status_nxt;
    res_offset_r <= res_offset_nxt;
    res_first_r  <= res_first_nxt;
    res_second_r <= res_second_nxt;
    res_total_r  <= res_total_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_total_r  <= out_total_nxt;
    out_fill_r   <= out_fill_nxt;
    out_free_r   <= out_free_nxt;
    out_full_r   <= out_full_nxt;
  end

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - ring buffer pointer control testbench
// Drives reserve/commit/consume/peek operations across several ring sizes
// with random gaps and output back-pressure. Every result beat is compared
// field by field against an in-bench model of the ring pointers.
// ----------------------------------------------------------------------------
module tb;

  localparam int SLOTS_MAX      = 1024;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 45;

  typedef struct packed {
    logic        status;
    logic [9:0]  offset;
    logic [10:0] first_len;
    logic [10:0] second_len;
    logic [10:0] total;
    logic [9:0]  fill_level;
    logic [9:0]  free_slots;
    logic        is_full;
  } ring_result_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [10:0] cfg_wr_data = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func     = '0;
  logic [10:0] in_count    = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic        out_status;
  logic [9:0]  out_offset;
  logic [10:0] out_first_len;
  logic [10:0] out_second_len;
  logic [10:0] out_total;
  logic [9:0]  out_fill_level;
  logic [9:0]  out_free_slots;
  logic        out_is_full;

  ring_buffer_pointer_control #(.RING_MAX(SLOTS_MAX)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_count       (in_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_offset     (out_offset),
    .out_first_len  (out_first_len),
    .out_second_len (out_second_len),
    .out_total      (out_total),
    .out_fill_level (out_fill_level),
    .out_free_slots (out_free_slots),
    .out_is_full    (out_is_full)
  );

  // ring model state
  int unsigned ring_slots   = SLOTS_MAX;
  int unsigned wr_ptr       = 0;
  int unsigned rd_ptr       = 0;
  int unsigned wr_tail_snap = 0;
  int unsigned rd_head_snap = 0;

  ring_result_t pending_results[$];
  int           error_count  = 0;
  int           stuck_cycles = 0;
  int           hold_req     = 0;
  bit           no_idle      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned occupancy(input int unsigned h, input int unsigned t);
    return (h >= t) ? h - t : h + ring_slots - t;
  endfunction

  function automatic int unsigned step_ptr(input int unsigned p, input int unsigned n);
    int unsigned q;
    q = p + n;
    if (q >= ring_slots) q -= ring_slots;
    return q;
  endfunction

  function automatic void space_runs(input int unsigned h, input int unsigned t,
                                     output int unsigned a, output int unsigned b);
    if (t <= h) begin
      if (t == 0) begin
        a = ring_slots - h - 1;
        b = 0;
      end else begin
        a = ring_slots - h;
        b = t - 1;
      end
    end else begin
      a = t - h - 1;
      b = 0;
    end
  endfunction

  function automatic void item_runs(input int unsigned h, input int unsigned t,
                                    input int unsigned n,
                                    output int unsigned a, output int unsigned b);
    int unsigned room;
    int unsigned rest;
    if (t < h) begin
      a = n;
      b = 0;
    end else begin
      room = ring_slots - t;
      a    = (room > n) ? n : room;
      rest = n - a;
      b    = (h < rest) ? h : rest;
    end
  endfunction

  function automatic ring_result_t ring_apply(input logic [2:0] f, input logic [10:0] c);
    ring_result_t r;
    int unsigned  cnt;
    int unsigned  a;
    int unsigned  b;
    int unsigned  seen;
    int unsigned  fill;
    r    = '0;
    cnt  = 32'(c);
    a    = 0;
    b    = 0;
    case (f)
      rbpc_pkg::FUNC_WR_RESERVE: begin
        space_runs(wr_ptr, wr_tail_snap, a, b);
        if (a + b == 0) begin
          wr_tail_snap = rd_ptr;
          space_runs(wr_ptr, wr_tail_snap, a, b);
        end
        r.offset     = 10'(wr_ptr);
        r.first_len  = 11'(a);
        r.second_len = 11'(b);
        r.total      = 11'(a + b);
      end
      rbpc_pkg::FUNC_WR_COMMIT: begin
        if (cnt > ring_slots - 1 - occupancy(wr_ptr, rd_ptr)) begin
          r.status = rbpc_pkg::STATUS_ERR;
        end else begin
          wr_ptr  = step_ptr(wr_ptr, cnt);
          r.total = 11'(cnt);
        end
      end
      rbpc_pkg::FUNC_RD_RESERVE: begin
        seen = occupancy(rd_head_snap, rd_ptr);
        if (seen == 0) begin
          rd_head_snap = wr_ptr;
          seen = occupancy(rd_head_snap, rd_ptr);
        end
        if (seen != 0) item_runs(rd_head_snap, rd_ptr, seen, a, b);
        r.offset     = 10'(rd_ptr);
        r.first_len  = 11'(a);
        r.second_len = 11'(b);
        r.total      = 11'(seen);
      end
      rbpc_pkg::FUNC_CONSUME: begin
        fill = occupancy(wr_ptr, rd_ptr);
        if (cnt == 0 || cnt > fill) begin
          r.status = rbpc_pkg::STATUS_ERR;
        end else begin
          rd_ptr  = step_ptr(rd_ptr, cnt);
          r.total = 11'(cnt);
        end
      end
      rbpc_pkg::FUNC_CONS_UPTO: begin
        seen = occupancy(rd_head_snap, rd_ptr);
        if (seen < cnt) begin
          rd_head_snap = wr_ptr;
          seen = occupancy(rd_head_snap, rd_ptr);
        end
        if (seen > cnt) seen = cnt;
        rd_ptr  = step_ptr(rd_ptr, seen);
        r.total = 11'(seen);
      end
      rbpc_pkg::FUNC_PEEK: begin
        seen = occupancy(rd_head_snap, rd_ptr);
        if (seen < cnt) begin
          rd_head_snap = wr_ptr;
          seen = occupancy(rd_head_snap, rd_ptr);
        end
        if (cnt != 0 && seen != 0)
          item_runs(rd_head_snap, rd_ptr, (seen < cnt) ? seen : cnt, a, b);
        r.offset     = 10'(rd_ptr);
        r.first_len  = 11'(a);
        r.second_len = 11'(b);
        r.total      = 11'(seen);
      end
      default: ;
    endcase
    fill         = occupancy(wr_ptr, rd_ptr);
    r.fill_level = 10'(fill);
    r.free_slots = 10'(ring_slots - 1 - fill);
    r.is_full    = (step_ptr(wr_ptr, 1) == rd_ptr);
    return r;
  endfunction

  // one beat on the input channel; gap drawn per beat
  task automatic send_op(input logic [2:0] f, input logic [10:0] c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_count <= c;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(ring_apply(f, c));
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_ring_size(input logic [10:0] v);
    quiesce();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    ring_slots   = (v < rbpc_pkg::SIZE_MIN) ? rbpc_pkg::SIZE_MIN :
                   (v > SLOTS_MAX) ? SLOTS_MAX : 32'(v);
    wr_ptr       = 0;
    rd_ptr       = 0;
    wr_tail_snap = 0;
    rd_head_snap = 0;
    @(posedge clk);
  endtask

  // mostly legal counts from the current fill, some noise and full-width values
  task automatic random_op();
    logic [2:0]  f;
    logic [10:0] c;
    int unsigned fill;
    int unsigned room;
    int unsigned pick;
    int unsigned sel;
    fill = occupancy(wr_ptr, rd_ptr);
    room = ring_slots - 1 - fill;
    pick = $urandom_range(0, 99);
    if (pick < 4)       f = 3'($urandom_range(6, 7));
    else if (pick < 30) f = rbpc_pkg::FUNC_WR_COMMIT;
    else if (pick < 42) f = rbpc_pkg::FUNC_WR_RESERVE;
    else if (pick < 54) f = rbpc_pkg::FUNC_RD_RESERVE;
    else if (pick < 72) f = rbpc_pkg::FUNC_CONSUME;
    else if (pick < 84) f = rbpc_pkg::FUNC_CONS_UPTO;
    else                f = rbpc_pkg::FUNC_PEEK;
    sel = $urandom_range(0, 9);
    if (sel == 9) begin
      c = 11'($urandom_range(0, 2047));
    end else if (sel >= 7) begin
      c = 11'($urandom_range(0, 8));
    end else begin
      case (f)
        rbpc_pkg::FUNC_WR_COMMIT: c = 11'((sel == 6) ? room : $urandom_range(0, room));
        rbpc_pkg::FUNC_CONSUME: begin
          if (fill == 0)     c = 11'($urandom_range(0, 2));
          else if (sel == 6) c = 11'(fill);
          else               c = 11'($urandom_range(1, fill));
        end
        rbpc_pkg::FUNC_CONS_UPTO, rbpc_pkg::FUNC_PEEK:
          c = 11'($urandom_range(0, fill + 2));
        default: c = 11'($urandom_range(0, 2047));
      endcase
    end
    send_op(f, c);
  endtask

  task automatic test_reset_size();
    send_op(rbpc_pkg::FUNC_WR_RESERVE, 11'd0);
    send_op(rbpc_pkg::FUNC_WR_COMMIT, 11'd1023);
    send_op(rbpc_pkg::FUNC_WR_COMMIT, 11'd1);
    send_op(rbpc_pkg::FUNC_WR_RESERVE, 11'd2047);
    send_op(rbpc_pkg::FUNC_PEEK, 11'd0);
    send_op(rbpc_pkg::FUNC_PEEK, 11'd2047);
    send_op(rbpc_pkg::FUNC_RD_RESERVE, 11'd0);
    send_op(rbpc_pkg::FUNC_CONSUME, 11'd0);
    send_op(rbpc_pkg::FUNC_CONSUME, 11'd1024);
    send_op(rbpc_pkg::FUNC_CONSUME, 11'd1000);
    send_op(rbpc_pkg::FUNC_WR_COMMIT, 11'd1000);
    send_op(rbpc_pkg::FUNC_WR_RESERVE, 11'd0);
    send_op(rbpc_pkg::FUNC_CONS_UPTO, 11'd2047);
    send_op(rbpc_pkg::FUNC_RD_RESERVE, 11'd0);
    send_op(rbpc_pkg::FUNC_WR_COMMIT, 11'd2047);
    send_op(3'd6, 11'd2047);
    send_op(3'd7, 11'd0);
    send_op(rbpc_pkg::FUNC_WR_COMMIT, 11'd0);
    send_op(rbpc_pkg::FUNC_CONS_UPTO, 11'd0);
  endtask

  task automatic test_size_clamp();
    set_ring_size(11'd0);
    send_op(rbpc_pkg::FUNC_WR_COMMIT, 11'd1);
    send_op(rbpc_pkg::FUNC_WR_RESERVE, 11'd0);
    send_op(rbpc_pkg::FUNC_WR_COMMIT, 11'd1);
    send_op(rbpc_pkg::FUNC_CONSUME, 11'd1);
    send_op(rbpc_pkg::FUNC_CONS_UPTO, 11'd1);
    set_ring_size(11'd1);
    send_op(rbpc_pkg::FUNC_RD_RESERVE, 11'd0);
  endtask

  task automatic test_random_ops();
    logic [10:0] size_plan[RANDOM_PHASES];
    size_plan[0] = 11'd2047;
    size_plan[1] = 11'd2;
    size_plan[2] = 11'd3;
    size_plan[3] = 11'($urandom_range(4, 40));
    size_plan[4] = 11'd1024;
    size_plan[5] = 11'($urandom_range(41, 1023));
    size_plan[6] = 11'($urandom_range(1025, 2046));
    size_plan[7] = 11'($urandom_range(4, 16));
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_ring_size(size_plan[p]);
      no_idle = (p % 3 == 2);
      repeat (PHASE_ITEMS) random_op();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    set_ring_size(11'd8);
    hold_req = 120;
    no_idle  = 1'b1;
    repeat (24) random_op();
    no_idle  = 1'b0;
    quiesce();
  endtask

  // result side: stall draw per beat, long hold on request
  initial begin
    int n;
    wait (rst_n);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 13);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic check_field(input string name, input logic [10:0] exp_v,
                             input logic [10:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    ring_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got total %0d",
                 $time, out_total);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", 11'(e.status), 11'(out_status));
        check_field("offset", 11'(e.offset), 11'(out_offset));
        check_field("first_len", e.first_len, out_first_len);
        check_field("second_len", e.second_len, out_second_len);
        check_field("total", e.total, out_total);
        check_field("fill_level", 11'(e.fill_level), 11'(out_fill_level));
        check_field("free_slots", 11'(e.free_slots), 11'(out_free_slots));
        check_field("is_full", 11'(e.is_full), 11'(out_is_full));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size();
    test_size_clamp();
    test_random_ops();
    test_backpressure();
    quiesce();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
